/* rtl/i2cms_pkg.sv */
// Shared types, command codes and phase constants for the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ_ACK  = 3'd4,
        CMD_READ_NACK = 3'd5
    } cmd_t;

    typedef logic [4:0] phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       sda_in;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam phase_t PH_WR_DATA_END = 5'd24;
    localparam phase_t PH_RD_DATA_END = 5'd16;
    localparam phase_t PH_RD_ACK0     = 5'd17;
    localparam phase_t PH_RD_ACK1     = 5'd18;
    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned WR_PHASES_PER_BIT = 3;

    function automatic logic [2:0] wr_bit_index(input phase_t k);
        logic [2:0] idx;
        idx = '0;
        for (int i = 1; i < BITS_PER_BYTE; i++) begin
            if (k >= 5'(WR_PHASES_PER_BIT * i)) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
// Top level of the I2C master bit sequencer: front, queue and back part.
// Usage:
// Each input item is one bus phase tick carrying command, tx_byte and sda_in.
// Every accepted item produces exactly one result item with the pin levels
// (scl_level, sda_level, drive_enable), busy_res, done_res, rx_byte and
// nack_seen for that phase. An idle sequencer starts the command of the item
// and emits its first phase for the same item; commands seen while busy are
// ignored. Both channels use valid and stall; an item moves when valid is
// high and stall is low.
// An accepted item is first written into a small queue by the front and then
// popped by the back into the result register. While the receiver does not
// stall, the block sustains one item per cycle: the back pops one item per cycle.
// When the receiver stalls, the result register holds, the queue fills and
// in_stall rises once the queue is full; no item is lost or repeated.
// Reset is asynchronous and active low: the queue empties, the sequencer is
// idle, and the pin levels return to SCL high, SDA high, drive disabled.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] command,
    input  wire logic [7:0] tx_byte,
    input  wire logic       sda_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_level,
    output logic            sda_level,
    output logic            drive_enable,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      rx_byte,
    output logic            nack_seen
);
    import i2cms_pkg::*;

    fifo_stat_t stat;
    entry_t     push_entry;
    entry_t     head_entry;
    logic       push;
    logic       pop;

    i2cms_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .tx_byte    (tx_byte),
        .sda_in     (sda_in),
        .stat       (stat),
        .push       (push),
        .push_entry (push_entry)
    );

    i2cms_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (stat)
    );

    i2cms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .stat         (stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .drive_enable (drive_enable),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .nack_seen    (nack_seen)
    );

endmodule

`default_nettype wire

/* rtl/i2cms_fifo.sv */
// Short queue of decoded items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire i2cms_pkg::entry_t  push_entry,
    input  wire logic               pop,
    output i2cms_pkg::entry_t       head_entry,
    output i2cms_pkg::fifo_stat_t   stat
);
    import i2cms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds its depth.");
    a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not grow on a push.");
    a_pop_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("Queue count did not shrink on a pop.");
`endif

endmodule

`default_nettype wire

/* rtl/i2cms_front.sv */
// Front part: accepts input items and classifies their command codes.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_front (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         command,
    input  wire logic [7:0]         tx_byte,
    input  wire logic               sda_in,
    input  wire i2cms_pkg::fifo_stat_t stat,
    output logic                    push,
    output i2cms_pkg::entry_t       push_entry
);
    import i2cms_pkg::*;

    cmd_t cmd_dec;

    always_comb
    begin
        case (command)
            3'(CMD_START):     cmd_dec = CMD_START;
            3'(CMD_STOP):      cmd_dec = CMD_STOP;
            3'(CMD_WRITE):     cmd_dec = CMD_WRITE;
            3'(CMD_READ_ACK):  cmd_dec = CMD_READ_ACK;
            3'(CMD_READ_NACK): cmd_dec = CMD_READ_NACK;
            default:           cmd_dec = CMD_NONE;
        endcase
    end

    assign in_stall           = stat.full;
    assign push               = in_valid && !stat.full;
    assign push_entry.cmd     = cmd_dec;
    assign push_entry.tx_byte = (cmd_dec == CMD_WRITE) ? tx_byte : 8'h00;
    assign push_entry.sda_in  = sda_in;

endmodule

`default_nettype wire

/* rtl/i2cms_back.sv */
// Back part: runs the bus phase sequencer and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire i2cms_pkg::entry_t     head_entry,
    input  wire i2cms_pkg::fifo_stat_t stat,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       scl_level,
    output logic                       sda_level,
    output logic                       drive_enable,
    output logic                       busy_res,
    output logic                       done_res,
    output logic [7:0]                 rx_byte,
    output logic                       nack_seen
);
    import i2cms_pkg::*;

    cmd_t       active_reg;
    cmd_t       active_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic       ack_reg;
    logic       ack_next;
    logic       out_valid_reg;
    logic       scl_reg;
    logic       scl_next;
    logic       sda_reg;
    logic       sda_next;
    logic       en_reg;
    logic       en_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done_reg;
    logic       done_next;
    logic [7:0] rx_reg;
    logic [7:0] rx_next;
    logic       nack_reg;
    logic       nack_next;

    logic       start_new;
    cmd_t       act;
    logic [7:0] shift_cur;
    phase_t     k;
    logic [2:0] wbit;
    phase_t     wsub;
    phase_t     rj;
    logic [2:0] rbit;
    logic       rel;
    phase_t     ackp;

    assign pop = !stat.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        start_new = (active_reg == CMD_NONE) && (head_entry.cmd != CMD_NONE);
        act       = start_new ? head_entry.cmd : active_reg;
        shift_cur = start_new ? head_entry.tx_byte : shift_reg;
        k         = start_new ? '0 : phase_reg;
        wbit      = wr_bit_index(k);
        wsub      = k - (5'({2'b00, wbit}) * 5'd3);
        rj        = k - 5'd1;
        rbit      = rj[3:1];
        rel       = ~shift_cur[0];
        ackp      = PH_WR_DATA_END + {4'b0000, rel};

        scl_next   = scl_reg;
        sda_next   = sda_reg;
        en_next    = en_reg;
        busy_next  = 1'b0;
        done_next  = 1'b0;
        rx_next    = 8'h00;
        nack_next  = 1'b0;
        shift_next = shift_cur;
        ack_next   = start_new ? 1'b0 : ack_reg;

        case (act)
            CMD_START:
            begin
                busy_next = 1'b1;
                en_next   = 1'b1;
                if (k == 5'd0)
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                else if (k == 5'd1)
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                else
                begin
                    scl_next  = 1'b0;
                    sda_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
            CMD_STOP:
            begin
                busy_next = 1'b1;
                en_next   = 1'b1;
                if (k == 5'd0)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                else if (k == 5'd1)
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                else if (k == 5'd2)
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                else
                begin
                    scl_next  = 1'b1;
                    sda_next  = 1'b1;
                    en_next   = 1'b0;
                    done_next = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                busy_next = 1'b1;
                en_next   = 1'b1;
                if (k < PH_WR_DATA_END)
                begin
                    scl_next = (wsub == 5'd1);
                    sda_next = shift_cur[3'd7 - wbit];
                end
                else if (k < ackp)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                else if (k == ackp)
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    ack_next = head_entry.sda_in;
                end
                else
                begin
                    scl_next  = 1'b0;
                    sda_next  = 1'b1;
                    done_next = 1'b1;
                    nack_next = ack_reg;
                end
            end
            CMD_READ_ACK, CMD_READ_NACK:
            begin
                busy_next = 1'b1;
                en_next   = 1'b1;
                if (k == 5'd0)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                else if (k <= PH_RD_DATA_END)
                begin
                    sda_next = 1'b1;
                    scl_next = ~rj[0];
                    if (!rj[0] && head_entry.sda_in)
                    begin
                        shift_next[3'd7 - rbit] = 1'b1;
                    end
                end
                else if (act == CMD_READ_ACK)
                begin
                    if (k == PH_RD_ACK0)
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    else if (k == PH_RD_ACK1)
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        sda_next  = 1'b1;
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    if (k == PH_RD_ACK0)
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        sda_next  = 1'b1;
                        done_next = 1'b1;
                    end
                end
                if (done_next)
                begin
                    rx_next = shift_next;
                end
            end
            default:
            begin
                busy_next = 1'b0;
            end
        endcase

        if (busy_next && !done_next)
        begin
            active_next = act;
            phase_next  = k + 5'd1;
        end
        else
        begin
            active_next = CMD_NONE;
            phase_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= CMD_NONE;
            phase_reg     <= '0;
            shift_reg     <= '0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            en_reg        <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rx_reg        <= '0;
            nack_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg    <= active_next;
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                ack_reg       <= ack_next;
                out_valid_reg <= 1'b1;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                en_reg        <= en_next;
                busy_reg      <= busy_next;
                done_reg      <= done_next;
                rx_reg        <= rx_next;
                nack_reg      <= nack_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = scl_reg;
    assign sda_level    = sda_reg;
    assign drive_enable = en_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign rx_byte      = rx_reg;
    assign nack_seen    = nack_reg;

`ifndef SYNTHESIS
    a_done_clears_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pop && done_next |=> active_reg == CMD_NONE && phase_reg == '0)
        else $error("Sequencer did not return to idle after the last phase.");
    a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> busy_reg)
        else $error("Done reported on an idle phase.");
    a_release_only_at_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(en_reg) |-> done_reg && busy_reg)
        else $error("Drive enable dropped outside the end of a stop.");
    a_start_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == CMD_START |-> phase_reg < 5'd3)
        else $error("Start sequence ran past its last phase.");
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(phase_reg) && $stable(active_reg))
        else $error("Sequencer advanced while its result was stalled.");
`endif

endmodule

`default_nettype wire

/* tb/sv/i2cms_bus_checker.sv */
// Checker for the I2C master bit sequencer: predicts each bus phase and compares result items.
`timescale 1ns / 1ps

module i2cms_bus_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [2:0] command,
    input  wire logic [7:0] tx_byte,
    input  wire logic       sda_in,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       scl_level,
    input  wire logic       sda_level,
    input  wire logic       drive_enable,
    input  wire logic       busy_res,
    input  wire logic       done_res,
    input  wire logic [7:0] rx_byte,
    input  wire logic       nack_seen,
    output int              fail_count,
    output int              pending
);
    import i2cms_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       en;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       nack;
    } bus_phase_t;

    phase_t     phase_cnt;
    logic [2:0] run_cmd;
    logic [7:0] shreg;
    logic       ack_bit;
    logic [2:0] pins;

    bus_phase_t expected_phases[$];

    task automatic advance_sequencer(input logic [2:0] code, input logic [7:0] data,
                                     input logic line, output bus_phase_t res);
        phase_t     k;
        phase_t     ackp;
        phase_t     j;
        logic [2:0] bitn;
        res = '0;
        if (run_cmd == CMD_NONE && code >= CMD_START && code <= CMD_READ_NACK)
        begin
            run_cmd = code;
            phase_cnt = '0;
            ack_bit = 1'b0;
            shreg = (code == CMD_WRITE) ? data : 8'h00;
        end
        k = phase_cnt;
        case (run_cmd)
            CMD_START:
            begin
                res.busy = 1'b1;
                if (k == 0) pins = 3'b111;
                else if (k == 1) pins = 3'b101;
                else
                begin
                    pins = 3'b001;
                    res.done = 1'b1;
                end
            end
            CMD_STOP:
            begin
                res.busy = 1'b1;
                if (k == 0) pins = 3'b001;
                else if (k == 1) pins = 3'b101;
                else if (k == 2) pins = 3'b111;
                else
                begin
                    pins = 3'b110;
                    res.done = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                res.busy = 1'b1;
                ackp = PH_WR_DATA_END + {4'b0000, ~shreg[0]};
                if (k < PH_WR_DATA_END)
                begin
                    bitn = 3'(k / 3);
                    pins = {((k % 3) == 1), shreg[7 - bitn], 1'b1};
                end
                else if (k < ackp) pins = 3'b011;
                else if (k == ackp)
                begin
                    pins = 3'b111;
                    ack_bit = line;
                end
                else
                begin
                    pins = 3'b011;
                    res.done = 1'b1;
                    res.nack = ack_bit;
                end
            end
            CMD_READ_ACK, CMD_READ_NACK:
            begin
                res.busy = 1'b1;
                if (k == 0) pins = 3'b011;
                else if (k <= PH_RD_DATA_END)
                begin
                    j = k - 1;
                    bitn = j[3:1];
                    if (!j[0])
                    begin
                        pins = 3'b111;
                        if (line) shreg[7 - bitn] = 1'b1;
                    end
                    else pins = 3'b011;
                end
                else if (run_cmd == CMD_READ_ACK)
                begin
                    if (k == PH_RD_ACK0) pins = 3'b001;
                    else if (k == PH_RD_ACK1) pins = 3'b101;
                    else
                    begin
                        pins = 3'b011;
                        res.done = 1'b1;
                    end
                end
                else
                begin
                    if (k == PH_RD_ACK0) pins = 3'b111;
                    else
                    begin
                        pins = 3'b011;
                        res.done = 1'b1;
                    end
                end
                if (res.done) res.rx = shreg;
            end
            default: run_cmd = CMD_NONE;
        endcase
        if (res.busy)
        begin
            if (res.done)
            begin
                run_cmd = CMD_NONE;
                phase_cnt = '0;
            end
            else phase_cnt = k + 1;
        end
        {res.scl, res.sda, res.en} = pins;
    endtask

    task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_phase_t want;
        bus_phase_t nxt;
        if (!rst_n)
        begin
            phase_cnt = '0;
            run_cmd = CMD_NONE;
            shreg = 8'h00;
            ack_bit = 1'b0;
            pins = 3'b110;
            expected_phases.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_phases.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual scl=%0b sda=%0b",
                             $time, scl_level, sda_level);
                    fail_count++;
                end
                else
                begin
                    want = expected_phases.pop_front();
                    cmp_field("scl_level", want.scl, scl_level);
                    cmp_field("sda_level", want.sda, sda_level);
                    cmp_field("drive_enable", want.en, drive_enable);
                    cmp_field("busy_res", want.busy, busy_res);
                    cmp_field("done_res", want.done, done_res);
                    cmp_field("rx_byte", want.rx, rx_byte);
                    cmp_field("nack_seen", want.nack, nack_seen);
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_sequencer(command, tx_byte, sda_in, nxt);
                expected_phases.push_back(nxt);
            end
            pending = expected_phases.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the I2C master bit sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import i2cms_pkg::*;

    localparam logic [2:0] CMD_UNUSED6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED7 = 3'd7;
    localparam int SDA_LOW = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;
    localparam int HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TICKS_PER_PHASE = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;

    int   fail_count;
    int   pending;
    int   snd_idle_pct = 0;
    int   rcv_stall_pct = 0;
    logic hold_req;
    logic hold_req_q = 1'b0;
    int   hold_left = 0;
    int   idle_run = 0;
    int   n_ticks = 0;
    int   n_writes = 0;
    int   n_reads = 0;
    int   n_framing = 0;

    always #1 clk = ~clk;

    i2c_master_bit_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .tx_byte      (tx_byte),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .drive_enable (drive_enable),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .nack_seen    (nack_seen)
    );

    i2cms_bus_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .tx_byte      (tx_byte),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .drive_enable (drive_enable),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .nack_seen    (nack_seen),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The receiver stalls at random, or holds off for a long stretch when asked.
    always @(posedge clk)
    begin
        hold_req_q <= hold_req;
        if (hold_req && !hold_req_q)
        begin
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired at %0t with %0d results outstanding.", $time, pending);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_tick(input logic [2:0] code, input logic [7:0] data, input logic line);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= code;
        tx_byte <= data;
        sda_in <= line;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_ticks++;
    endtask

    function automatic logic line_level(input int mode);
        if (mode == SDA_RAND) return 1'($urandom_range(1));
        return (mode == SDA_HIGH);
    endfunction

    // Sends the command item and then filler items until the sequence is done.
    task automatic issue_cmd(input logic [2:0] code, input logic [7:0] data, input int sda_mode);
        int len;
        case (code)
            CMD_START:     len = 3;
            CMD_STOP:      len = 4;
            CMD_WRITE:     len = 26 + int'(!data[0]);
            CMD_READ_ACK:  len = 20;
            CMD_READ_NACK: len = 19;
            default:       len = 1;
        endcase
        if (code == CMD_WRITE) n_writes++;
        else if (code == CMD_READ_ACK || code == CMD_READ_NACK) n_reads++;
        else if (code == CMD_START || code == CMD_STOP) n_framing++;
        send_tick(code, data, line_level(sda_mode));
        for (int i = 1; i < len; i++)
        begin
            send_tick(3'($urandom_range(7)), 8'($urandom), line_level(sda_mode));
        end
    endtask

    task automatic bus_transfer();
        int   nbytes;
        logic rd_dir;
        nbytes = $urandom_range(1, 3);
        rd_dir = 1'($urandom_range(1));
        issue_cmd(CMD_START, 8'($urandom), SDA_RAND);
        issue_cmd(CMD_WRITE, 8'($urandom), SDA_RAND);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                issue_cmd(($urandom_range(1) != 0) ? CMD_UNUSED6 : CMD_NONE, 8'($urandom),
                          SDA_RAND);
            end
            if (!rd_dir) issue_cmd(CMD_WRITE, 8'($urandom), SDA_RAND);
            else if (i == nbytes - 1) issue_cmd(CMD_READ_NACK, 8'($urandom), SDA_RAND);
            else issue_cmd(CMD_READ_ACK, 8'($urandom), SDA_RAND);
        end
        if ($urandom_range(4) != 0) issue_cmd(CMD_STOP, 8'($urandom), SDA_RAND);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int phase_end;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_NONE;
        tx_byte = 8'h00;
        sda_in = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        issue_cmd(CMD_NONE, 8'h00, SDA_LOW);
        issue_cmd(CMD_START, 8'hFF, SDA_RAND);
        issue_cmd(CMD_WRITE, 8'h00, SDA_LOW);
        issue_cmd(CMD_WRITE, 8'hFF, SDA_HIGH);
        issue_cmd(CMD_WRITE, 8'hA5, SDA_RAND);
        issue_cmd(CMD_READ_ACK, 8'h00, SDA_HIGH);
        issue_cmd(CMD_READ_NACK, 8'hFF, SDA_LOW);
        issue_cmd(CMD_READ_ACK, 8'h3C, SDA_RAND);
        issue_cmd(CMD_STOP, 8'h00, SDA_RAND);
        issue_cmd(CMD_UNUSED6, 8'hFF, SDA_HIGH);
        issue_cmd(CMD_UNUSED7, 8'h00, SDA_LOW);
        issue_cmd(CMD_NONE, 8'hFF, SDA_HIGH);
        wait_quiet();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct <= 0;
                end
                1:
                begin
                    snd_idle_pct = 58;
                    rcv_stall_pct <= 0;
                end
                2:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct <= 58;
                end
                default:
                begin
                    snd_idle_pct = 21;
                    rcv_stall_pct <= 21;
                end
            endcase
            phase_end = n_ticks + TICKS_PER_PHASE;
            if (ph == 0) hold_req <= 1'b1;
            while (n_ticks < phase_end)
            begin
                if ($urandom_range(99) < 85) bus_transfer();
                else issue_cmd(3'($urandom_range(7)), 8'($urandom), SDA_RAND);
                hold_req <= 1'b0;
            end
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d bus phase items: %0d writes, %0d reads, %0d start/stop commands.",
                 n_ticks, n_writes, n_reads, n_framing);
        $display("Pacing: free flow, sender gaps, receiver stalls, both, and a long hold-off.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/i2cms_pkg.sv
rtl/i2cms_fifo.sv
rtl/i2cms_front.sv
rtl/i2cms_back.sv
rtl/i2c_master_bit_sequencer.sv
tb/sv/i2cms_bus_checker.sv
tb/sv/testbench.sv
